// ===== hw/rtl/mmul_pkg.sv =====
// Shared types and codes for the fixed-point matrix multiplier.
package mmul_pkg;

  // Request codes carried in s_tuser.
  localparam logic [1:0] REQ_WR_A = 2'd0;
  localparam logic [1:0] REQ_WR_B = 2'd1;
  localparam logic [1:0] REQ_MUL  = 2'd2;

  localparam int VALUE_W = 32;
  localparam int PROD_W  = 2 * VALUE_W;

  typedef enum logic [1:0] {
    CMD_WR_A,
    CMD_WR_B,
    CMD_MUL
  } cmd_kind_t;

  // One classified command as it sits in the queue.
  typedef struct packed {
    cmd_kind_t                  kind;
    logic [1:0]                 row;
    logic [1:0]                 col;
    logic signed [VALUE_W-1:0]  value;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

endpackage

// ===== hw/rtl/matrix_multiply_4x4_core.sv =====
// Top level of the fixed-point DIM x DIM matrix multiplier.
//
// Requests arrive as words on the s_ stream: s_tuser picks write-A, write-B or multiply,
// and s_tdata carries row, column and a signed Q16.16 value. Writes are executed in the
// back end while no multiply runs, so loads stream in at one word per cycle. A multiply
// leaves the queue and then walks DIM*DIM*DIM multiply-accumulates (64 at DIM = 4)
// through one 32x32 multiplier fed by the two element stores, one store read per store per
// cycle while no result word is stalled; that loop sets the rate. Each result word is
// registered after the store read, product and final accumulate, row-major, m_tlast on the
// final one; a stalled result word freezes the whole multiply pipeline until it is taken.
// Each element is the exact sum of DIM products floored by FRAC_BITS and clipped to 32
// bits, m_tuser flagging a clip. A short command queue sits between the front end and the
// back end, so the front keeps taking words while a multiply runs until the queue fills.
// Request code 3 and writes outside the matrix are accepted and dropped. Stores have no
// reset; reading an element that was never written returns whatever the RAM holds.
module matrix_multiply_4x4_core #(
  parameter int DIM         = 4,
  parameter int FRAC_BITS   = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // row_index[1:0], col_index[3:2], element_value[35:4], zero
  input  logic [1:0]  s_tuser,   // req_type[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // out_row[1:0], out_col[3:2], product_value[35:4], zero
  output logic        m_tuser,   // saturated[0]
  output logic        m_tlast    // last_flag
);

  logic           push;
  mmul_pkg::cmd_t push_cmd;
  logic           q_full;
  logic           q_valid;
  mmul_pkg::cmd_t q_head;
  logic           pop;

  // Decode and filter incoming words.
  mmul_front #(.DIM(DIM)) u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Hold commands while the back end is busy with a multiply.
  mmul_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  // Execute writes, run the multiply pipeline and drive the result word.
  mmul_back #(.DIM(DIM), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_cmd    (q_head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== hw/rtl/mmul_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mmul_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/mmul_front.sv =====
// Front end: accept request words, classify them and drop the ones that do nothing.
module mmul_front #(
  parameter int DIM = 4
) (
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [39:0]         s_tdata,
  input  logic [1:0]          s_tuser,
  input  logic                q_full,
  output logic                push,
  output mmul_pkg::cmd_t      push_cmd
);

  logic                keep;
  logic [1:0]          row;
  logic [1:0]          col;
  logic                in_range;
  mmul_pkg::cmd_kind_t kind;

  assign row      = s_tdata[1:0];
  assign col      = s_tdata[3:2];
  assign in_range = (int'(row) < DIM) && (int'(col) < DIM);
  assign s_tready = !q_full;

  always_comb begin
    keep = 1'b0;
    kind = mmul_pkg::CMD_MUL;
    case (s_tuser)
      mmul_pkg::REQ_WR_A: begin
        keep = in_range;
        kind = mmul_pkg::CMD_WR_A;
      end
      mmul_pkg::REQ_WR_B: begin
        keep = in_range;
        kind = mmul_pkg::CMD_WR_B;
      end
      mmul_pkg::REQ_MUL: begin
        keep = 1'b1;
        kind = mmul_pkg::CMD_MUL;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // Pack kind, row, column and value into one queue entry.
  assign push_cmd = {kind, row, col, s_tdata[35:4]};
  assign push     = s_tvalid && !q_full && keep;

endmodule

// ===== hw/rtl/mmul_queue.sv =====
// Short command queue between the front end and the execution back end.
module mmul_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mmul_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output mmul_pkg::cmd_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mmul_pkg::cmd_t   slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== hw/rtl/mmul_back.sv =====
// Back end: execute stored writes and run the multiply-accumulate pipeline.
module mmul_back #(
  parameter int DIM       = 4,
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  mmul_pkg::cmd_t q_cmd,
  output logic           pop,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [39:0]    m_tdata,
  output logic           m_tuser,
  output logic           m_tlast
);

  localparam int IDX_W  = $clog2(DIM);
  localparam int AW     = $clog2(DIM * DIM);
  localparam int VW     = mmul_pkg::VALUE_W;
  localparam int ACC_W  = mmul_pkg::PROD_W + $clog2(DIM);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DIM - 1);
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sh0000_0000_7fff_ffff);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-64'sh0000_0000_8000_0000);

  mmul_pkg::back_state_t state, state_next;

  logic             we_a;
  logic             we_b;
  logic             issue;
  logic             adv;
  logic [AW-1:0]    wr_addr;
  logic [AW-1:0]    a_addr;
  logic [AW-1:0]    b_addr;
  logic [VW-1:0]    a_q;
  logic [VW-1:0]    b_q;

  logic [IDX_W-1:0] i;
  logic [IDX_W-1:0] j;
  logic [IDX_W-1:0] k;
  logic             run_done;

  // Stage 1: RAM data and tags
  logic             v1;
  logic [IDX_W-1:0] i1, j1;
  logic             kf1, kl1, last1;
  // Stage 2: product
  logic             v2;
  logic signed [mmul_pkg::PROD_W-1:0] prod;
  logic [IDX_W-1:0] i2, j2;
  logic             kf2, kl2, last2;
  // Stage 3: completed sum
  logic             v3;
  logic signed [ACC_W-1:0] acc;
  logic [IDX_W-1:0] i3, j3;
  logic             last3;

  logic signed [ACC_W-1:0] shifted;
  logic signed [VW-1:0]    sat_val;
  logic                    sat_flag;

  logic             o_valid;
  logic [1:0]       o_row;
  logic [1:0]       o_col;
  logic [VW-1:0]    o_val;
  logic             o_sat;
  logic             o_last;

  assign adv      = !o_valid || m_tready;
  assign run_done = (i == IDX_LAST) && (j == IDX_LAST) && (k == IDX_LAST);

  always_comb begin
    state_next = state;
    case (state)
      mmul_pkg::BK_IDLE: begin
        if (q_valid && q_cmd.kind == mmul_pkg::CMD_MUL) begin
          state_next = mmul_pkg::BK_RUN;
        end
      end
      mmul_pkg::BK_RUN: begin
        if (adv && run_done) begin
          state_next = mmul_pkg::BK_IDLE;
        end
      end
      default: state_next = mmul_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop   = 1'b0;
    we_a  = 1'b0;
    we_b  = 1'b0;
    issue = 1'b0;
    case (state)
      mmul_pkg::BK_IDLE: begin
        pop  = q_valid;
        we_a = q_valid && (q_cmd.kind == mmul_pkg::CMD_WR_A);
        we_b = q_valid && (q_cmd.kind == mmul_pkg::CMD_WR_B);
      end
      mmul_pkg::BK_RUN: begin
        issue = 1'b1;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mmul_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Walk k fastest, then column, then row.
  always_ff @(posedge clk) begin
    if (rst || state == mmul_pkg::BK_IDLE) begin
      i <= '0;
      j <= '0;
      k <= '0;
    end else if (adv) begin
      if (k == IDX_LAST) begin
        k <= '0;
        if (j == IDX_LAST) begin
          j <= '0;
          i <= (i == IDX_LAST) ? '0 : i + 1'b1;
        end else begin
          j <= j + 1'b1;
        end
      end else begin
        k <= k + 1'b1;
      end
    end
  end

  assign wr_addr = AW'(int'(q_cmd.row) * DIM + int'(q_cmd.col));
  assign a_addr  = AW'(int'(i) * DIM + int'(k));
  assign b_addr  = AW'(int'(k) * DIM + int'(j));

  mmul_ram #(.WIDTH(VW), .DEPTH(DIM * DIM)) u_store_a (
    .clk     (clk),
    .we      (we_a),
    .wr_addr (wr_addr),
    .wr_data (q_cmd.value),
    .re      (adv),
    .rd_addr (a_addr),
    .rd_data (a_q)
  );

  mmul_ram #(.WIDTH(VW), .DEPTH(DIM * DIM)) u_store_b (
    .clk     (clk),
    .we      (we_b),
    .wr_addr (wr_addr),
    .wr_data (q_cmd.value),
    .re      (adv),
    .rd_addr (b_addr),
    .rd_data (b_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      v3      <= 1'b0;
      o_valid <= 1'b0;
    end else if (adv) begin
      v1      <= issue;
      v2      <= v1;
      v3      <= v2 && kl2;
      o_valid <= v3;
    end
  end

  // Floor by the fraction width, then clip to the 32-bit range.
  assign shifted = acc >>> FRAC_BITS;

  always_comb begin
    sat_flag = 1'b1;
    sat_val  = VW'(shifted);
    if (shifted > SAT_HI) begin
      sat_val = VW'(SAT_HI);
    end else if (shifted < SAT_LO) begin
      sat_val = VW'(SAT_LO);
    end else begin
      sat_flag = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      i1    <= i;
      j1    <= j;
      kf1   <= (k == '0);
      kl1   <= (k == IDX_LAST);
      last1 <= run_done;

      prod  <= signed'(a_q) * signed'(b_q);
      i2    <= i1;
      j2    <= j1;
      kf2   <= kf1;
      kl2   <= kl1;
      last2 <= last1;

      if (v2) begin
        acc <= kf2 ? ACC_W'(prod) : acc + ACC_W'(prod);
      end
      i3    <= i2;
      j3    <= j2;
      last3 <= last2;

      o_row  <= 2'(i3);
      o_col  <= 2'(j3);
      o_val  <= sat_val;
      o_sat  <= sat_flag;
      o_last <= last3;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = {4'b0, o_val, o_col, o_row};
  assign m_tuser  = o_sat;
  assign m_tlast  = o_last;

endmodule

// ===== hw/rtl/mmul_checker.sv =====
// Port-level checks for the matrix multiplier, bound to the top level.
module mmul_checker #(
  parameter int DIM = 4
) (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  // Hold a stalled result word.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result word changed while stalled");

  // Drop any result after reset.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // The final element sits in the bottom-right corner.
  a_last_corner: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> (m_tdata[1:0] == 2'(DIM - 1)) && (m_tdata[3:2] == 2'(DIM - 1)))
    else $error("last flag away from the final element");

  // A clipped element holds one of the range limits.
  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata[35:4] == 32'h7fff_ffff) || (m_tdata[35:4] == 32'h8000_0000))
    else $error("saturation flag on an unclipped value");

endmodule

bind matrix_multiply_4x4_core mmul_checker #(.DIM(DIM)) u_mmul_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
